/* design/upr_pkg.sv */
// upr_pkg: shared constants, types and tables for the underwater pixel restoration pipeline
// no dependencies
package upr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int STEPS     = 4;

	// pipeline depths of the units
	localparam int RATIO_LAT  = 4;
	localparam int DEPTH_LAT  = 5;
	localparam int EXP_LAT    = 6;
	localparam int REST_LAT   = 4;
	localparam int SAMPLE_DLY = RATIO_LAT + DEPTH_LAT + EXP_LAT;
	localparam int PIPE_LAT   = SAMPLE_DLY + REST_LAT;
	localparam int DEPTH_TAP  = RATIO_LAT + DEPTH_LAT - 1;
	localparam int EXP_TAP    = SAMPLE_DLY - 1;

	// widths
	localparam int D_W     = FRAC_BITS + 1;
	localparam int Y_W     = 20;
	localparam int Z_W     = 21;
	localparam int E_W     = 23;
	localparam int RECIP_W = 21;
	localparam int GAIN_W  = 17;

	localparam logic [D_W-1:0]     ONE       = D_W'(1) << FRAC_BITS;
	localparam logic [RECIP_W-1:0] RECIP_CAP = RECIP_W'(20) << FRAC_BITS;
	localparam logic [11:0]        AIR_MIN   = 12'd16;
	localparam logic [11:0]        AIR_RST   = 12'd4080;

	localparam logic [GAIN_W-1:0] GAIN_BLUE  = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_GREEN = 17'd72090;
	localparam logic [GAIN_W-1:0] GAIN_RED   = 17'd85197;

	// round(ln(1 + 2^-k) * 2^16), k = 0..16
	localparam logic [15:0] LOG_TAB [0:FRAC_BITS] = '{
		16'd45426, 16'd26573, 16'd14624, 16'd7719, 16'd3973, 16'd2017,
		16'd1016, 16'd510, 16'd256, 16'd128, 16'd64, 16'd32, 16'd16,
		16'd8, 16'd4, 16'd2, 16'd1
	};

	typedef enum logic [1:0] {
		REG_AIRLIGHT,
		REG_ATTEN_BLUE,
		REG_ATTEN_GREEN,
		REG_ATTEN_RED
	} cfg_reg_t;

	// blue / airlight ratio handed from divider to depth unit
	typedef struct packed {
		logic        ge;
		logic [15:0] q;
	} ratio_t;

endpackage

/* design/upr_ratio.sv */
// upr_ratio: pipelined restoring divider, x = floor(blue*16*2^16 / airlight)
// depends on upr_pkg
module upr_ratio (
	input  logic            clk,
	input  logic            en,
	input  logic [7:0]      blue,
	input  logic [11:0]     aq,
	output upr_pkg::ratio_t ratio
);
	import upr_pkg::*;

	logic [11:0] rem_s [RATIO_LAT];
	logic [15:0] quo_s [RATIO_LAT];
	logic        ge_s  [RATIO_LAT];
	logic [11:0] rem_d [RATIO_LAT];
	logic [15:0] quo_d [RATIO_LAT];
	logic        ge_d  [RATIO_LAT];

	// four quotient bits per stage
	always_comb begin
		logic [11:0] r;
		logic [12:0] r2;
		logic [15:0] q;
		logic        ge;
		for (int g = 0; g < RATIO_LAT; g++) begin
			if (g == 0) begin
				ge = ({blue, 4'b0} >= aq);
				r  = ge ? 12'd0 : {blue, 4'b0};
				q  = 16'd0;
			end else begin
				ge = ge_s[g-1];
				r  = rem_s[g-1];
				q  = quo_s[g-1];
			end
			for (int i = 0; i < STEPS; i++) begin
				r2 = {r, 1'b0};
				if (r2 >= {1'b0, aq}) begin
					r = 12'(r2 - {1'b0, aq});
					q = {q[14:0], 1'b1};
				end else begin
					r = r2[11:0];
					q = {q[14:0], 1'b0};
				end
			end
			rem_d[g] = r;
			quo_d[g] = q;
			ge_d[g]  = ge;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < RATIO_LAT; g++) begin
				rem_s[g] <= rem_d[g];
				quo_s[g] <= quo_d[g];
				ge_s[g]  <= ge_d[g];
			end
		end
	end

	assign ratio.ge = ge_s[RATIO_LAT-1];
	assign ratio.q  = quo_s[RATIO_LAT-1];

endmodule

/* design/upr_depth.sv */
// upr_depth: depth d = clamp(-ln(x), 0, 1) by normalization and shift-add log steps
// depends on upr_pkg
module upr_depth (
	input  logic                  clk,
	input  logic                  en,
	input  upr_pkg::ratio_t       ratio,
	output logic [upr_pkg::D_W-1:0] depth
);
	import upr_pkg::*;

	logic [D_W-1:0] x_s    [DEPTH_LAT];
	logic [Y_W-1:0] y_s    [DEPTH_LAT];
	logic           zero_s [DEPTH_LAT];
	logic           one_s  [DEPTH_LAT];
	logic [D_W-1:0] x_d    [DEPTH_LAT];
	logic [Y_W-1:0] y_d    [DEPTH_LAT];

	// normalize, then four log steps per stage
	always_comb begin
		logic [3:0]     m;
		logic           pow2;
		logic [4:0]     n;
		logic [D_W-1:0] x;
		logic [D_W:0]   nx;
		logic [Y_W-1:0] y;
		m = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (ratio.q[i]) m = 4'(i);
		end
		pow2   = ((ratio.q & (ratio.q - 16'd1)) == 16'd0);
		n      = 5'(5'd15 - {1'b0, m}) + {4'b0, pow2};
		x_d[0] = D_W'({1'b0, ratio.q} << n);
		y_d[0] = Y_W'(n * LOG_TAB[0]);
		for (int g = 1; g < DEPTH_LAT; g++) begin
			x = x_s[g-1];
			y = y_s[g-1];
			for (int i = 0; i < STEPS; i++) begin
				nx = {1'b0, x} + {1'b0, x >> ((g - 1) * STEPS + i + 1)};
				if (nx <= {1'b0, ONE}) begin
					x = nx[D_W-1:0];
					y = y + Y_W'(LOG_TAB[(g - 1) * STEPS + i + 1]);
				end
			end
			x_d[g] = x;
			y_d[g] = y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= ratio.ge;
			one_s[0]  <= (ratio.q == 16'd0);
			for (int g = 0; g < DEPTH_LAT; g++) begin
				x_s[g] <= x_d[g];
				y_s[g] <= y_d[g];
			end
			for (int g = 1; g < DEPTH_LAT; g++) begin
				zero_s[g] <= zero_s[g-1];
				one_s[g]  <= one_s[g-1];
			end
		end
	end

	// special cases and clamp to one
	always_comb begin
		if (zero_s[DEPTH_LAT-1]) begin
			depth = '0;
		end else if (one_s[DEPTH_LAT-1] || y_s[DEPTH_LAT-1] > Y_W'(ONE)) begin
			depth = ONE;
		end else begin
			depth = y_s[DEPTH_LAT-1][D_W-1:0];
		end
	end

endmodule

/* design/upr_exp.sv */
// upr_exp: reciprocal transmission 1/t = min(exp(beta*d), 20) by shift-add exp steps
// depends on upr_pkg
module upr_exp (
	input  logic                        clk,
	input  logic                        en,
	input  logic [15:0]                 beta,
	input  logic [upr_pkg::D_W-1:0]     depth,
	output logic [upr_pkg::RECIP_W-1:0] recip
);
	import upr_pkg::*;

	localparam int NS = EXP_LAT - 1;

	logic [Z_W-1:0] z_s1;
	logic [Z_W-1:0] z_s [NS];
	logic [E_W-1:0] e_s [NS];
	logic [Z_W-1:0] z_d [NS];
	logic [E_W-1:0] e_d [NS];
	logic [32:0]    prod;

	assign prod = 33'(beta) * 33'(depth) + 33'd2048;

	// doublings first, then four exp steps per stage
	always_comb begin
		logic [2:0]     n;
		logic [Z_W-1:0] z;
		logic [E_W-1:0] e;
		n = 3'd0;
		for (int i = 1; i <= 5; i++) begin
			if (z_s1 >= Z_W'(i * LOG_TAB[0])) n = 3'(i);
		end
		z_d[0] = Z_W'(z_s1 - Z_W'(n * LOG_TAB[0]));
		e_d[0] = E_W'(1) << (FRAC_BITS + int'(n));
		for (int g = 1; g < NS; g++) begin
			z = z_s[g-1];
			e = e_s[g-1];
			for (int i = 0; i < STEPS; i++) begin
				if (z >= Z_W'(LOG_TAB[(g - 1) * STEPS + i + 1])) begin
					z = z - Z_W'(LOG_TAB[(g - 1) * STEPS + i + 1]);
					e = e + (e >> ((g - 1) * STEPS + i + 1));
				end
			end
			z_d[g] = z;
			e_d[g] = e;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= prod[32:12];
			for (int g = 0; g < NS; g++) begin
				z_s[g] <= z_d[g];
				e_s[g] <= e_d[g];
			end
		end
	end

	// cap at 20
	assign recip = (e_s[NS-1] > E_W'(RECIP_CAP)) ? RECIP_CAP : e_s[NS-1][RECIP_W-1:0];

endmodule

/* design/upr_restore.sv */
// upr_restore: J = clamp((I - A)/t + A, 0, 255), channel gain, round and saturate
// depends on upr_pkg
module upr_restore (
	input  logic                        clk,
	input  logic                        en,
	input  logic [7:0]                  sample,
	input  logic [11:0]                 aq,
	input  logic [upr_pkg::RECIP_W-1:0] recip,
	input  logic [upr_pkg::GAIN_W-1:0]  gain,
	output logic [7:0]                  pix
);
	import upr_pkg::*;

	localparam logic signed [35:0] J_TOP = 36'sd255 <<< (4 + FRAC_BITS);

	logic signed [13:0] diff;
	logic signed [35:0] prod_s2_in;
	logic signed [35:0] prod_s1;
	logic        [27:0] j_s2;
	logic        [44:0] m_s3;
	logic        [7:0]  pix_s4;
	logic signed [35:0] j_sum;
	logic        [45:0] rnd;

	assign diff       = $signed({2'b0, sample, 4'b0}) - $signed({2'b0, aq});
	assign prod_s2_in = 36'(diff * $signed({1'b0, recip}));
	assign j_sum      = prod_s1 + $signed(36'(aq) << FRAC_BITS);
	assign rnd        = {1'b0, m_s3} + (46'd1 << 35);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_s2_in;
			// clamp to the sample range
			if (j_sum < 0) begin
				j_s2 <= '0;
			end else if (j_sum > J_TOP) begin
				j_s2 <= J_TOP[27:0];
			end else begin
				j_s2 <= j_sum[27:0];
			end
			m_s3   <= 45'(j_s2) * 45'(gain);
			pix_s4 <= (rnd[45:36] > 10'd255) ? 8'd255 : rnd[43:36];
		end
	end

	assign pix = pix_s4;

endmodule

/* design/underwater_pixel_restoration.sv */
// underwater_pixel_restoration: top level, config registers, valid pipeline, output skid stage
// depends on upr_pkg, upr_ratio, upr_depth, upr_exp, upr_restore
// an input transaction reaches output valid through the divider, log and exp shift-add
// stages plus the restore multipliers
// throughput: one pixel per cycle while the skid stage is empty; a held output parks there
// reset: config registers take their reset values, valid bits and skid stage clear
module underwater_pixel_restoration (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          blue_in,
	input  logic [7:0]          green_in,
	input  logic [7:0]          red_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          blue_out,
	output logic [7:0]          green_out,
	output logic [7:0]          red_out,
	input  logic                cfg_we,
	input  upr_pkg::cfg_reg_t   cfg_index,
	input  logic [15:0]         cfg_data
);
	import upr_pkg::*;

	logic [11:0] airlight_q;
	logic [15:0] atten_blue_q;
	logic [15:0] atten_green_q;
	logic [15:0] atten_red_q;
	logic [11:0] aq;

	logic                adv;
	logic [PIPE_LAT-1:0] valid_q;
	logic [7:0]          blue_dly  [SAMPLE_DLY];
	logic [7:0]          green_dly [SAMPLE_DLY];
	logic [7:0]          red_dly   [SAMPLE_DLY];

	ratio_t             ratio;
	logic [D_W-1:0]     depth;
	logic [RECIP_W-1:0] recip_blue;
	logic [RECIP_W-1:0] recip_green;
	logic [RECIP_W-1:0] recip_red;
	logic [7:0]         pix_blue;
	logic [7:0]         pix_green;
	logic [7:0]         pix_red;

	logic       skid_full_q;
	logic [7:0] skid_blue_q;
	logic [7:0] skid_green_q;
	logic [7:0] skid_red_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			airlight_q    <= AIR_RST;
			atten_blue_q  <= '0;
			atten_green_q <= '0;
			atten_red_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AIRLIGHT:    airlight_q    <= cfg_data[11:0];
				REG_ATTEN_BLUE:  atten_blue_q  <= cfg_data;
				REG_ATTEN_GREEN: atten_green_q <= cfg_data;
				REG_ATTEN_RED:   atten_red_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// airlight floor of one
	assign aq = (airlight_q < AIR_MIN) ? AIR_MIN : airlight_q;

	// whole pipeline moves unless the skid stage holds a result
	assign adv      = !skid_full_q;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// samples wait for their reciprocal transmission
	always_ff @(posedge clk) begin
		if (adv) begin
			blue_dly[0]  <= blue_in;
			green_dly[0] <= green_in;
			red_dly[0]   <= red_in;
			for (int i = 1; i < SAMPLE_DLY; i++) begin
				blue_dly[i]  <= blue_dly[i-1];
				green_dly[i] <= green_dly[i-1];
				red_dly[i]   <= red_dly[i-1];
			end
		end
	end

	upr_ratio u_ratio (
		.clk   (clk),
		.en    (adv),
		.blue  (blue_in),
		.aq    (aq),
		.ratio (ratio)
	);

	upr_depth u_depth (
		.clk   (clk),
		.en    (adv),
		.ratio (ratio),
		.depth (depth)
	);

	upr_exp u_exp_blue (
		.clk   (clk),
		.en    (adv),
		.beta  (atten_blue_q),
		.depth (depth),
		.recip (recip_blue)
	);

	upr_exp u_exp_green (
		.clk   (clk),
		.en    (adv),
		.beta  (atten_green_q),
		.depth (depth),
		.recip (recip_green)
	);

	upr_exp u_exp_red (
		.clk   (clk),
		.en    (adv),
		.beta  (atten_red_q),
		.depth (depth),
		.recip (recip_red)
	);

	upr_restore u_rest_blue (
		.clk    (clk),
		.en     (adv),
		.sample (blue_dly[SAMPLE_DLY-1]),
		.aq     (aq),
		.recip  (recip_blue),
		.gain   (GAIN_BLUE),
		.pix    (pix_blue)
	);

	upr_restore u_rest_green (
		.clk    (clk),
		.en     (adv),
		.sample (green_dly[SAMPLE_DLY-1]),
		.aq     (aq),
		.recip  (recip_green),
		.gain   (GAIN_GREEN),
		.pix    (pix_green)
	);

	upr_restore u_rest_red (
		.clk    (clk),
		.en     (adv),
		.sample (red_dly[SAMPLE_DLY-1]),
		.aq     (aq),
		.recip  (recip_red),
		.gain   (GAIN_RED),
		.pix    (pix_red)
	);

	// output skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ready) skid_full_q <= 1'b0;
		end else if (valid_q[PIPE_LAT-1] && !out_ready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_blue_q  <= pix_blue;
			skid_green_q <= pix_green;
			skid_red_q   <= pix_red;
		end
	end

	assign out_valid = skid_full_q || valid_q[PIPE_LAT-1];
	assign blue_out  = skid_full_q ? skid_blue_q  : pix_blue;
	assign green_out = skid_full_q ? skid_green_q : pix_green;
	assign red_out   = skid_full_q ? skid_red_q   : pix_red;

	// a result left untaken moves into the skid stage
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_full_q && valid_q[PIPE_LAT-1] && !out_ready |=> skid_full_q)
		else $error("untaken result not parked in skid stage");

	// a taken skid entry frees the pipeline
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && out_ready |=> !skid_full_q && in_ready)
		else $error("skid stage did not drain");

	// depth stays within [0, 1]
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[DEPTH_TAP] |-> depth <= ONE)
		else $error("depth out of range");

	// red reciprocal transmission stays within [1, 20]
	a_recip_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[EXP_TAP] |-> recip_red >= RECIP_W'(ONE) && recip_red <= RECIP_CAP)
		else $error("reciprocal transmission out of range");

endmodule

/* dv/tb_underwater_pixel_restoration.sv */
// tb_underwater_pixel_restoration: self-checking testbench for the pixel restoration block
// depends on upr_pkg and underwater_pixel_restoration; predicts each restored pixel
// with its own bit-accurate fixed-point model of depth, transmission and gain
module tb_underwater_pixel_restoration;
	timeunit 1ns;
	timeprecision 1ps;
	import upr_pkg::*;

	localparam int FB       = 16;
	localparam int WDOG_MAX = 4000;
	localparam int DRAIN_WAIT = PIPE_LAT + 6;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  blue_in = '0, green_in = '0, red_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  blue_out, green_out, red_out;
	logic        cfg_we = 1'b0;
	cfg_reg_t    cfg_index = REG_AIRLIGHT;
	logic [15:0] cfg_data = '0;

	// predictor copy of the register file
	logic [11:0] air_q = AIR_RST;
	logic [15:0] beta_b = '0, beta_g = '0, beta_r = '0;

	pixel_t restored_q[$];
	int     mismatches = 0;
	int     pixels_sent = 0;
	int     pixels_checked = 0;
	int     cfg_writes = 0;
	int     tx_idle_pct = 0;
	int     rx_idle_pct = 0;
	int     quiet_cycles = 0;

	underwater_pixel_restoration dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.blue_in(blue_in), .green_in(green_in), .red_in(red_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.blue_out(blue_out), .green_out(green_out), .red_out(red_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// depth from blue / airlight via shift-add log
	function automatic logic [63:0] depth_est(logic [63:0] b, logic [63:0] aq);
		logic [63:0] one, x, y, nx;
		one = 64'd1 << FB;
		x = ((b * 16) << FB) / aq;
		y = 0;
		if (x >= one) return 0;
		if (x == 0) return one;
		while ((x << 1) <= one) begin
			x = x << 1;
			y += LOG_TAB[0];
		end
		for (int k = 1; k <= FB; k++) begin
			nx = x + (x >> k);
			if (nx <= one) begin
				x = nx;
				y += LOG_TAB[k];
			end
		end
		return (y > one) ? one : y;
	endfunction

	// reciprocal transmission exp(beta*d), capped at 20
	function automatic logic [63:0] inv_trans(logic [63:0] beta, logic [63:0] d);
		logic [63:0] cap, z, e;
		cap = 64'd20 << FB;
		z = (beta * d + 64'd2048) >> 12;
		e = 64'd1 << FB;
		while (z >= LOG_TAB[0] && e < cap) begin
			z -= LOG_TAB[0];
			e = e << 1;
		end
		for (int k = 1; k <= FB; k++) begin
			if (z >= LOG_TAB[k]) begin
				z -= LOG_TAB[k];
				e += e >> k;
			end
		end
		return (e > cap) ? cap : e;
	endfunction

	// restored channel with gain, rounded and saturated
	function automatic logic [7:0] channel_out(logic [63:0] s, logic [63:0] aq,
			logic [63:0] recip, logic [63:0] gain);
		longint j, top;
		logic [63:0] r;
		top = longint'(64'd255 << (4 + FB));
		j = (longint'(s * 16) - longint'(aq)) * longint'(recip) + longint'(aq << FB);
		if (j < 0) j = 0;
		if (j > top) j = top;
		r = (64'(j) * gain + (64'd1 << (4 + FB + 15))) >> (4 + FB + 16);
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	function automatic pixel_t restore_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		logic [63:0] aq, d;
		pixel_t p;
		aq = (air_q < 16) ? 64'd16 : 64'(air_q);
		d = depth_est(b, aq);
		p.blue  = channel_out(b, aq, inv_trans(beta_b, d), 64'd65536);
		p.green = channel_out(g, aq, inv_trans(beta_g, d), 64'(GAIN_GREEN));
		p.red   = channel_out(r, aq, inv_trans(beta_r, d), 64'(GAIN_RED));
		return p;
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && out_valid && out_ready) begin
			if (restored_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction b=%0d g=%0d r=%0d",
						blue_out, green_out, red_out);
			end else begin
				exp_px = restored_q.pop_front();
				pixels_checked++;
				if (exp_px.blue !== blue_out || exp_px.green !== green_out ||
						exp_px.red !== red_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
							exp_px.blue, exp_px.green, exp_px.red,
							blue_out, green_out, red_out);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	// send one pixel, with random idle gap before it
	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		blue_in = b;
		green_in = g;
		red_in = r;
		do @(posedge clk); while (!in_ready);
		restored_q.push_back(restore_pixel(b, g, r));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (restored_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// write one register while the pipeline is empty
	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_AIRLIGHT:    air_q = val[11:0];
			REG_ATTEN_BLUE:  beta_b = val;
			REG_ATTEN_GREEN: beta_g = val;
			REG_ATTEN_RED:   beta_r = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_all(logic [15:0] a, logic [15:0] bb, logic [15:0] bg, logic [15:0] br);
		write_reg(REG_AIRLIGHT, a);
		write_reg(REG_ATTEN_BLUE, bb);
		write_reg(REG_ATTEN_GREEN, bg);
		write_reg(REG_ATTEN_RED, br);
	endtask

	// reset values: identity restoration apart from the gains
	task automatic test_reset_defaults;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd200, 8'd180);
		send_pixel(8'd10, 8'd233, 8'd196);
	endtask

	// field extremes, airlight floor, blue at or over airlight, depth and t clamps
	task automatic test_directed;
		set_all(16'd4095, 16'd65535, 16'd65535, 16'd65535);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd128, 8'd128);
		send_pixel(8'd20, 8'd250, 8'd5);
		set_all(16'd5, 16'd4096, 16'd8192, 16'd12288);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd255, 8'd255);
		write_reg(REG_AIRLIGHT, 16'hF000);
		send_pixel(8'd0, 8'd77, 8'd200);
		write_reg(REG_AIRLIGHT, 16'd2000);
		send_pixel(8'd125, 8'd10, 8'd240);
		send_pixel(8'd126, 8'd60, 8'd60);
		send_pixel(8'd30, 8'd0, 8'd255);
		send_pixel(8'd2, 8'd255, 8'd0);
		write_reg(REG_ATTEN_RED, 16'd0);
		send_pixel(8'd50, 8'd100, 8'd150);
		write_reg(REG_AIRLIGHT, 16'd16);
		send_pixel(8'd0, 8'd3, 8'd200);
		send_pixel(8'd1, 8'd0, 8'd0);
	endtask

	// random pixels under one random register setting
	task automatic test_random_block(int n);
		logic [15:0] a;
		int mode;
		mode = $urandom_range(3);
		case (mode)
			0: a = 16'($urandom_range(16, 4095));
			1: a = 16'($urandom_range(0, 40));
			2: a = 16'($urandom_range(3000, 4095));
			default: a = 16'($urandom);
		endcase
		set_all(a, 16'($urandom), 16'($urandom_range(0, 20000)), 16'($urandom));
		for (int i = 0; i < n; i++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_random;
		tx_idle_pct = 12;
		rx_idle_pct = 65;
		repeat (3) test_random_block(45);
		tx_idle_pct = 65;
		rx_idle_pct = 12;
		repeat (3) test_random_block(45);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (3) test_random_block(45);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed();
		test_random();
		drain();
		$display("sent %0d pixels, checked %0d results, %0d register writes",
			pixels_sent, pixels_checked, cfg_writes);
		$display("covered airlight floor and extremes, depth and transmission clamps");
		if (mismatches == 0 && restored_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
design/upr_pkg.sv
design/upr_ratio.sv
design/upr_depth.sv
design/upr_exp.sv
design/upr_restore.sv
design/underwater_pixel_restoration.sv
dv/tb_underwater_pixel_restoration.sv
